@@ rtl/core/efp_pkg.sv @@
`default_nettype none

package efp_pkg;

  // Frame layout
  localparam int unsigned PosW = 6;

  localparam logic [PosW-1:0] PosHdr0   = 6'd0;
  localparam logic [PosW-1:0] PosHdr1   = 6'd1;
  localparam logic [PosW-1:0] PosHdr2   = 6'd2;
  localparam logic [PosW-1:0] SumFirst  = 6'd3;
  localparam logic [PosW-1:0] PosHdr5   = 6'd5;
  localparam logic [PosW-1:0] PosHdr6   = 6'd6;
  localparam logic [PosW-1:0] AttPos    = 6'd32;
  localparam logic [PosW-1:0] MedPos    = 6'd34;
  localparam logic [PosW-1:0] FrameLast = 6'd35;

  // Header byte values (byte 4 is a wildcard)
  localparam logic [7:0] SyncByte  = 8'hAA;
  localparam logic [7:0] HdrByte2  = 8'h20;
  localparam logic [7:0] HdrByte3  = 8'h02;
  localparam logic [7:0] HdrByte5  = 8'h83;
  localparam logic [7:0] HdrByte6  = 8'h18;

  // Frame status codes
  localparam logic StatusOk     = 1'b0;
  localparam logic StatusCsumErr = 1'b1;

  typedef struct packed {
    logic       check;
    logic [7:0] want;
  } efp_hdr_t;

  typedef struct packed {
    logic       frame_status;
    logic [7:0] attention_level;
    logic [7:0] meditation_level;
  } efp_result_t;

  // Expected header byte at a frame position, if that position is checked
  function automatic efp_hdr_t hdr_expect(input logic [PosW-1:0] pos);
    efp_hdr_t h;
    h.check = 1'b1;
    h.want  = SyncByte;
    unique case (pos)
      PosHdr0:  h.want = SyncByte;
      PosHdr1:  h.want = SyncByte;
      PosHdr2:  h.want = HdrByte2;
      SumFirst: h.want = HdrByte3;
      PosHdr5:  h.want = HdrByte5;
      PosHdr6:  h.want = HdrByte6;
      default:  h.check = 1'b0;
    endcase
    return h;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/efp_byte_if.sv @@
`default_nettype none

// Stream of received serial bytes, one per beat
interface efp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

@@ rtl/core/efp_result_if.sv @@
`default_nettype none

// Stream of frame results, one per beat
interface efp_result_if;
  logic       valid;
  logic       ready;
  logic       frame_status;
  logic [7:0] attention_level;
  logic [7:0] meditation_level;

  modport source (output valid, output frame_status, output attention_level,
                  output meditation_level, input ready);
  modport sink   (input valid, input frame_status, input attention_level,
                  input meditation_level, output ready);
endinterface

`default_nettype wire

@@ rtl/core/efp_frame_tracker.sv @@
`default_nettype none

// Frame position tracking, header check, checksum and value capture.
// State moves on each step_i; the result for the checksum byte is combinational.
module efp_frame_tracker (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [7:0]         rx_byte_i,
  output logic                    emit_o,
  output efp_pkg::efp_result_t    res_o
);
  import efp_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [7:0]      cap_att_q, cap_att_d;
  logic [7:0]      cap_med_q, cap_med_d;
  logic [7:0]      held_att_q, held_att_d;
  logic [7:0]      held_med_q, held_med_d;

  efp_hdr_t hdr;
  logic     hdr_bad;
  logic     csum_ok;

  // Decode of the current byte
  assign hdr     = hdr_expect(pos_q);
  assign hdr_bad = hdr.check && (rx_byte_i != hdr.want);
  assign csum_ok = (~sum_q) == rx_byte_i;
  assign emit_o  = pos_q >= FrameLast;

  // Result for the checksum byte: held values as they stand after this frame
  always_comb begin
    res_o.frame_status     = csum_ok ? StatusOk : StatusCsumErr;
    res_o.attention_level  = csum_ok ? cap_att_q : held_att_q;
    res_o.meditation_level = csum_ok ? cap_med_q : held_med_q;
  end

  // Next state
  always_comb begin
    pos_d      = pos_q;
    sum_d      = sum_q;
    cap_att_d  = cap_att_q;
    cap_med_d  = cap_med_q;
    held_att_d = held_att_q;
    held_med_d = held_med_q;
    if (step_i) begin
      if (emit_o) begin
        pos_d = '0;
        if (csum_ok) begin
          held_att_d = cap_att_q;
          held_med_d = cap_med_q;
        end
      end else if (hdr_bad) begin
        // failing byte is dropped, not retried as a new sync byte
        pos_d = '0;
      end else begin
        if (pos_q == SumFirst) begin
          sum_d = rx_byte_i;
        end else if (pos_q > SumFirst) begin
          sum_d = sum_q + rx_byte_i;
        end
        if (pos_q == AttPos) begin
          cap_att_d = rx_byte_i;
        end
        if (pos_q == MedPos) begin
          cap_med_d = rx_byte_i;
        end
        pos_d = pos_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_q      <= '0;
      cap_att_q  <= '0;
      cap_med_q  <= '0;
      held_att_q <= '0;
      held_med_q <= '0;
    end else begin
      pos_q      <= pos_d;
      sum_q      <= sum_d;
      cap_att_q  <= cap_att_d;
      cap_med_q  <= cap_med_d;
      held_att_q <= held_att_d;
      held_med_q <= held_med_d;
    end
  end

  // Position stays inside the frame
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= FrameLast)
    else $error("frame position beyond checksum byte");

  // Checksum byte always restarts the frame
  a_emit_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o |=> pos_q == '0)
    else $error("frame did not restart after checksum byte");

  // Good frame publishes the captured values
  a_good_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && emit_o && csum_ok |=>
      held_att_q == $past(cap_att_q) && held_med_q == $past(cap_med_q))
    else $error("held values not updated on good checksum");

endmodule

`default_nettype wire

@@ rtl/core/eeg_frame_parser.sv @@
// A byte is registered in the input stage on acceptance and processed from
// there; the checksum byte's result is registered in the result register.
// Throughput: one byte per cycle; the input stage stalls only when a frame
// result is due and the result register is still occupied.
// Reset (asynchronous, active low) clears the frame position, sum, captured
// and held values, and both valid flags.
`default_nettype none

module eeg_frame_parser (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  efp_byte_if.sink      byte_i,
  efp_result_if.source  result_o
);
  import efp_pkg::*;

  logic        in_valid_q, in_valid_d;
  logic [7:0]  in_byte_q;
  logic        out_valid_q, out_valid_d;
  efp_result_t out_res_q;

  logic        emit;
  efp_result_t res;
  logic        out_free;
  logic        advance;

  // Input stage moves on unless it carries a result with nowhere to go
  assign out_free     = !out_valid_q || result_o.ready;
  assign advance      = in_valid_q && (!emit || out_free);
  assign byte_i.ready = !in_valid_q || advance;

  efp_frame_tracker u_tracker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .rx_byte_i (in_byte_q),
    .emit_o    (emit),
    .res_o     (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (byte_i.valid && byte_i.ready) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance && emit) begin
      out_valid_d = 1'b1;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  // Control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.rx_byte;
    end
    if (advance && emit) begin
      out_res_q <= res;
    end
  end

  assign result_o.valid            = out_valid_q;
  assign result_o.frame_status     = out_res_q.frame_status;
  assign result_o.attention_level  = out_res_q.attention_level;
  assign result_o.meditation_level = out_res_q.meditation_level;

  // An accepted beat always lands in the input stage
  a_in_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_i.valid && byte_i.ready |=> in_valid_q)
    else $error("accepted byte lost");

  // A pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |-> !(advance && emit))
    else $error("result register overwritten while stalled");

  // A stalled result beat holds valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |=> out_valid_q && $stable(out_res_q))
    else $error("pending result changed while stalled");

endmodule

`default_nettype wire
